// ----- sv/servo_can_command_frame_packer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Servo CAN command frame packer: assertion macros
// Implication checks, dropped when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SERVO_CAN_COMMAND_FRAME_PACKER_UNIT_ASSERT_SVH
`define SERVO_CAN_COMMAND_FRAME_PACKER_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define SCFP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SCFP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SCFP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/scfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg
// Codes, limits and register indexes of the servo CAN command frame packer.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int unsigned IdWidth   = 11;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxWidth  = 3;

  localparam logic [7:0]  CODE_POSITION = 8'hF5;
  localparam logic [7:0]  CODE_SPEED    = 8'hF6;
  localparam logic [3:0]  LEN_POSITION  = 4'd8;
  localparam logic [3:0]  LEN_SPEED     = 4'd5;

  localparam logic [11:0] SPEED_CAP = 12'd3000;
  localparam logic [7:0]  ACCEL_CAP = 8'd255;

  localparam logic signed [31:0] AXIS_MAX = 32'sh007F_FFFF;
  localparam logic signed [31:0] AXIS_MIN = -32'sh007F_FFFF;

  localparam logic [IdWidth-1:0] CAN_ID_RESET = 11'd1;

  typedef enum logic [0:0] {
    MODE_POSITION = 1'b0,
    MODE_SPEED    = 1'b1
  } mode_t;

  typedef enum logic [IdxWidth-1:0] {
    REG_CAN_ID       = 3'd0,
    REG_VELOCITY_MIN = 3'd1,
    REG_VELOCITY_MAX = 3'd2,
    REG_ACCEL_MIN    = 3'd3,
    REG_ACCEL_MAX    = 3'd4,
    REG_POSITION_MIN = 3'd5,
    REG_POSITION_MAX = 3'd6
  } reg_idx_t;

endpackage

// ----- sv/servo_can_command_frame_packer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_can_command_frame_packer_unit
// Turns one motion event into one servo CAN command frame.
// ----------------------------------------------------------------------------
// One frame per cycle sustained unless the output stalls; each event passes
// from input beat to output beat through four register stages: limit
// selection and position limits, speed/acceleration clamp and 24-bit axis
// saturation, cap and byte packing, checksum into the output register. A stalled
// output holds the pipeline; gaps fill in as the stages drain. Configuration is
// sampled directly by the stages, so write it only while no event is in flight.
// ----------------------------------------------------------------------------
module servo_can_command_frame_packer_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_we,
  input  logic [scfp_pkg::IdxWidth-1:0]         cfg_index,
  input  logic [scfp_pkg::DataWidth-1:0]        cfg_data,
  // event channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic [31:0]                           velocity,
  input  logic [31:0]                           accel,
  input  logic signed [31:0]                    position,
  // frame channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [scfp_pkg::IdWidth-1:0]          frame_id,
  output logic [3:0]                            frame_length,
  output logic [7:0]                            byte0,
  output logic [7:0]                            byte1,
  output logic [7:0]                            byte2,
  output logic [7:0]                            byte3,
  output logic [7:0]                            byte4,
  output logic [7:0]                            byte5,
  output logic [7:0]                            byte6,
  output logic [7:0]                            byte7
);
  import scfp_pkg::*;

  `include "servo_can_command_frame_packer_unit_assert.svh"

  // configuration registers
  logic [IdWidth-1:0] can_id;
  logic [31:0]        velocity_min, velocity_max, accel_min, accel_max;
  logic signed [31:0] position_min, position_max;

  // pipeline valid bits and advance
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  // stage 1
  logic               mode1, neg1;
  logic [31:0]        vel1, acc1, vlo1, alo1;
  logic signed [31:0] pos1;
  logic [31:0]        vlo_next, alo_next;
  logic signed [31:0] pos1_next;

  // stage 2
  logic               mode2, neg2;
  logic [31:0]        spd2, acc2;
  logic [23:0]        axis2;
  logic [31:0]        spd2_next, acc2_next;
  logic [23:0]        axis2_next;

  // stage 3
  logic               mode3;
  logic [7:0]         b0_3, b1_3, b2_3, b3_3, b4_3, b5_3, b6_3;
  logic [11:0]        spd_cap;
  logic [7:0]         acc_cap;
  logic [7:0]         b1_next;

  // stage 4
  logic [7:0]         sum_head, sum_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      can_id       <= CAN_ID_RESET;
      velocity_min <= '0;
      velocity_max <= '0;
      accel_min    <= '0;
      accel_max    <= '0;
      position_min <= '0;
      position_max <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAN_ID:       can_id       <= cfg_data[IdWidth-1:0];
        REG_VELOCITY_MIN: velocity_min <= cfg_data;
        REG_VELOCITY_MAX: velocity_max <= cfg_data;
        REG_ACCEL_MIN:    accel_min    <= cfg_data;
        REG_ACCEL_MAX:    accel_max    <= cfg_data;
        REG_POSITION_MIN: position_min <= cfg_data;
        REG_POSITION_MAX: position_max <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv3     = !out_valid || out_ready;
  assign adv2     = !v3 || adv3;
  assign adv1     = !v2 || adv2;
  assign in_ready = !v1 || adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v1        <= in_valid;
      if (adv1)     v2        <= v1;
      if (adv2)     v3        <= v2;
      if (adv3)     out_valid <= v3;
    end
  end

  // stage 1: effective lower limits, configured position limits
  always_comb begin
    vlo_next = (velocity_max != '0 && velocity_min > velocity_max) ? velocity_max
                                                                   : velocity_min;
    alo_next = (accel_max != '0 && accel_min > accel_max) ? accel_max : accel_min;
    pos1_next = position;
    if (position_max > position_min) begin
      priority if (position < position_min) pos1_next = position_min;
      else if (position > position_max)     pos1_next = position_max;
      else                                  pos1_next = position;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mode1 <= mode;
      neg1  <= position[31];
      vel1  <= velocity;
      acc1  <= accel;
      vlo1  <= vlo_next;
      alo1  <= alo_next;
      pos1  <= pos1_next;
    end
  end

  // stage 2: clamp to range, 24-bit symmetric saturation
  always_comb begin
    priority if (vel1 < vlo1)                         spd2_next = vlo1;
    else if (velocity_max != '0 && vel1 > velocity_max) spd2_next = velocity_max;
    else                                              spd2_next = vel1;

    priority if (acc1 < alo1)                      acc2_next = alo1;
    else if (accel_max != '0 && acc1 > accel_max)  acc2_next = accel_max;
    else                                           acc2_next = acc1;

    priority if (pos1 > AXIS_MAX) axis2_next = AXIS_MAX[23:0];
    else if (pos1 < AXIS_MIN)     axis2_next = AXIS_MIN[23:0];
    else                          axis2_next = pos1[23:0];
  end

  always_ff @(posedge clk) begin
    if (adv1 && v1) begin
      mode2 <= mode1;
      neg2  <= neg1;
      spd2  <= spd2_next;
      acc2  <= acc2_next;
      axis2 <= axis2_next;
    end
  end

  // stage 3: caps and byte packing; unused bytes zero so one sum fits both
  assign spd_cap = (spd2 > 32'(SPEED_CAP)) ? SPEED_CAP : spd2[11:0];
  assign acc_cap = (acc2 > 32'(ACCEL_CAP)) ? ACCEL_CAP : acc2[7:0];
  assign b1_next = (mode2 == MODE_SPEED) ? {neg2, 3'b000, spd_cap[11:8]}
                                         : {4'b0000, spd_cap[11:8]};

  always_ff @(posedge clk) begin
    if (adv2 && v2) begin
      mode3 <= mode2;
      b0_3  <= (mode2 == MODE_SPEED) ? CODE_SPEED : CODE_POSITION;
      b1_3  <= b1_next;
      b2_3  <= spd_cap[7:0];
      b3_3  <= acc_cap;
      b4_3  <= (mode2 == MODE_SPEED) ? 8'h00 : axis2[23:16];
      b5_3  <= (mode2 == MODE_SPEED) ? 8'h00 : axis2[15:8];
      b6_3  <= (mode2 == MODE_SPEED) ? 8'h00 : axis2[7:0];
    end
  end

  // stage 4: checksum, mod 256
  assign sum_head = can_id[7:0] + b0_3 + b1_3 + b2_3 + b3_3;
  assign sum_all  = sum_head + b4_3 + b5_3 + b6_3;

  always_ff @(posedge clk) begin
    if (adv3 && v3) begin
      frame_id <= can_id;
      byte0    <= b0_3;
      byte1    <= b1_3;
      byte2    <= b2_3;
      byte3    <= b3_3;
      byte5    <= b5_3;
      byte6    <= b6_3;
      if (mode3 == MODE_SPEED) begin
        frame_length <= LEN_SPEED;
        byte4        <= sum_head;
        byte7        <= 8'h00;
      end else begin
        frame_length <= LEN_POSITION;
        byte4        <= b4_3;
        byte7        <= sum_all;
      end
    end
  end

  `SCFP_ASSERT_IMPLY(a_len_code, clk, rst, out_valid,
    (frame_length == LEN_SPEED && byte0 == CODE_SPEED) ||
    (frame_length == LEN_POSITION && byte0 == CODE_POSITION))
  `SCFP_ASSERT_IMPLY(a_speed_tail_zero, clk, rst, out_valid && frame_length == LEN_SPEED,
    byte5 == 8'h00 && byte6 == 8'h00 && byte7 == 8'h00)
  `SCFP_ASSERT_IMPLY(a_full_stall, clk, rst, v1 && v2 && v3 && out_valid && !out_ready,
    !in_ready)
  `SCFP_ASSERT_NEXT(a_out_fill, clk, rst, v3 && !out_valid, out_valid)

endmodule
